// ===== src/ndsa_pkg.sv =====
package ndsa_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned R2_W    = 50;
  localparam int unsigned BOUND_W = 50;
  localparam int unsigned DSQ_W   = 64;
  localparam int unsigned DSUM_W  = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // tdata layouts
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = DSQ_W + 3 * DSUM_W + CNT_W;

  localparam int unsigned NUM_SHELLS_DEF  = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [BOUND_W-1:0] BOUND_SQ_1_RST = BOUND_W'(37748736);
  localparam logic [BOUND_W-1:0] BOUND_SQ_MAX   = {BOUND_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SQ_1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SQ_2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SQ_3 = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // One classified item handed from the front to the back
  typedef struct packed {
    cmd_e                     cmd;
    logic [SEL_W-1:0]         shell;
    logic                     shell_ok;
    logic [R2_W-1:0]          r2;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } pair_item_t;

endpackage

// ===== src/neighbor_distance_shell_accumulator.sv =====
// Bins neighbor pairs into radius shells and keeps saturating sums per shell.
// One transfer per clock is taken on the input stream while it is not
// stalled. A pair spends two register stages in the front (difference, then
// squares) before its squared distance is summed, compared against the
// configured squared bounds and written into the queue; the back then
// updates the chosen shell's sums as it pops the queue head (a clear zeroes
// every shell). A read result leaves from an output register; while that
// register is held by a stalled sink, reads wait in the queue and the input
// stalls once the queue (QUEUE_DEPTH entries) is full and the second front
// stage holds a pair. Accumulates and clears give no output. Bounds must be
// written only while the block is idle; the block itself does not enforce this.
module neighbor_distance_shell_accumulator import ndsa_pkg::*; #(
  parameter int unsigned NUM_SHELLS  = NUM_SHELLS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [BOUND_W-1:0]    cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // own_x, own_y, own_z, other_x, other_y, other_z, shell_select, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // sum_dist_sq, sum_dx, sum_dy, sum_dz, pair_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ITEM_W = $bits(pair_item_t);

  logic       push, queue_ready, pop, head_valid;
  pair_item_t push_item, head_item;
  logic [ITEM_W-1:0] head_bits;

  ndsa_front #(
    .NUM_SHELLS(NUM_SHELLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_cmd_i     (s_axis_tuser),
    .push_o       (push),
    .push_item_o  (push_item),
    .queue_ready_i(queue_ready)
  );

  ndsa_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_item),
    .ready_o    (queue_ready),
    .pop_i      (pop),
    .head_o     (head_bits),
    .valid_o    (head_valid)
  );

  assign head_item = pair_item_t'(head_bits);

  ndsa_back #(
    .NUM_SHELLS(NUM_SHELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== src/ndsa_front.sv =====
module ndsa_front import ndsa_pkg::*; #(
  parameter int unsigned NUM_SHELLS = NUM_SHELLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [BOUND_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic [CMD_W-1:0]     in_cmd_i,
  output logic                 push_o,
  output pair_item_t           push_item_o,
  input  logic                 queue_ready_i
);

  logic [BOUND_W-1:0] bound_q [3];

  logic                     adv;
  logic                     s1_valid_q, s2_valid_q;
  cmd_e                     s1_cmd_q, s2_cmd_q;
  logic [SEL_W-1:0]         s1_sel_q, s2_sel_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic signed [DIFF_W-1:0] s2_dx_q, s2_dy_q, s2_dz_q;
  logic [R2_W-1:0]          s2_sqx_q, s2_sqy_q, s2_sqz_q;

  logic signed [POS_W-1:0]  own_x, own_y, own_z, oth_x, oth_y, oth_z;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic signed [SQ_W-1:0]   sqx, sqy, sqz;
  logic [R2_W-1:0]          r2;
  logic [SEL_W-1:0]         bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q[0] <= BOUND_SQ_1_RST;
      bound_q[1] <= BOUND_SQ_MAX;
      bound_q[2] <= BOUND_SQ_MAX;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BOUND_SQ_1: bound_q[0] <= cfg_wdata_i;
        CFG_BOUND_SQ_2: bound_q[1] <= cfg_wdata_i;
        CFG_BOUND_SQ_3: bound_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole front moves as one; it only waits on a full queue
  assign adv        = !s2_valid_q || queue_ready_i;
  assign in_ready_o = adv;

  assign own_x = in_data_i[POS_W-1:0];
  assign own_y = in_data_i[2*POS_W-1:POS_W];
  assign own_z = in_data_i[3*POS_W-1:2*POS_W];
  assign oth_x = in_data_i[4*POS_W-1:3*POS_W];
  assign oth_y = in_data_i[5*POS_W-1:4*POS_W];
  assign oth_z = in_data_i[6*POS_W-1:5*POS_W];

  assign dx_d = DIFF_W'(own_x) - DIFF_W'(oth_x);
  assign dy_d = DIFF_W'(own_y) - DIFF_W'(oth_y);
  assign dz_d = DIFF_W'(own_z) - DIFF_W'(oth_z);

  assign sqx = s1_dx_q * s1_dx_q;
  assign sqy = s1_dy_q * s1_dy_q;
  assign sqz = s1_dz_q * s1_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q <= cmd_e'(in_cmd_i);
      s1_sel_q <= in_data_i[6*POS_W+SEL_W-1:6*POS_W];
      s1_dx_q  <= dx_d;
      s1_dy_q  <= dy_d;
      s1_dz_q  <= dz_d;
      s2_cmd_q <= s1_cmd_q;
      s2_sel_q <= s1_sel_q;
      s2_dx_q  <= s1_dx_q;
      s2_dy_q  <= s1_dy_q;
      s2_dz_q  <= s1_dz_q;
      s2_sqx_q <= R2_W'(sqx);
      s2_sqy_q <= R2_W'(sqy);
      s2_sqz_q <= R2_W'(sqz);
    end
  end

  // Squares are each below 2^48, so the sum fits without carry out
  assign r2 = s2_sqx_q + s2_sqy_q + s2_sqz_q;

  // First shell whose outer bound exceeds r2; the last shell is open
  always_comb begin
    bin = SEL_W'(NUM_SHELLS - 1);
    for (int k = NUM_SHELLS - 2; k >= 0; k--) begin
      if (bound_q[k] > r2) begin
        bin = SEL_W'(k);
      end
    end
  end

  always_comb begin
    push_item_o.cmd      = s2_cmd_q;
    push_item_o.r2       = r2;
    push_item_o.dx       = s2_dx_q;
    push_item_o.dy       = s2_dy_q;
    push_item_o.dz       = s2_dz_q;
    if (s2_cmd_q == CMD_READ) begin
      push_item_o.shell    = s2_sel_q;
      push_item_o.shell_ok = {1'b0, s2_sel_q} < (SEL_W + 1)'(NUM_SHELLS);
    end else begin
      push_item_o.shell    = bin;
      push_item_o.shell_ok = 1'b1;
    end
  end

  // Drop NOP commands here
  assign push_o = s2_valid_q && queue_ready_i && (s2_cmd_q != CMD_NOP);

endmodule

// ===== src/ndsa_queue.sv =====
module ndsa_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = count_q != CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/ndsa_back.sv =====
module ndsa_back import ndsa_pkg::*; #(
  parameter int unsigned NUM_SHELLS = NUM_SHELLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  pair_item_t            head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned SH_W = (NUM_SHELLS > 1) ? $clog2(NUM_SHELLS) : 1;

  logic [DSQ_W-1:0]  dsq_q [NUM_SHELLS];
  logic [DSUM_W-1:0] dx_q  [NUM_SHELLS];
  logic [DSUM_W-1:0] dy_q  [NUM_SHELLS];
  logic [DSUM_W-1:0] dz_q  [NUM_SHELLS];
  logic [CNT_W-1:0]  cnt_q [NUM_SHELLS];

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_free, load_out;
  logic [SH_W-1:0]       idx;
  logic [DSQ_W:0]        dsq_sum;
  logic [DSQ_W-1:0]      dsq_new;
  logic [DSUM_W-1:0]     dx_new, dy_new, dz_new;
  logic [CNT_W-1:0]      cnt_new;

  function automatic logic [DSUM_W-1:0] sat_add(input logic [DSUM_W-1:0] acc,
                                                input logic [DIFF_W-1:0] d);
    logic [DSUM_W:0] s;
    s = {acc[DSUM_W-1], acc} + (DSUM_W + 1)'($signed(d));
    if (s[DSUM_W] != s[DSUM_W-1]) begin
      // clamp toward the sign of the true sum
      sat_add = s[DSUM_W] ? {1'b1, {(DSUM_W-1){1'b0}}} : {1'b0, {(DSUM_W-1){1'b1}}};
    end else begin
      sat_add = s[DSUM_W-1:0];
    end
  endfunction

  assign idx      = head_i.shell[SH_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = head_valid_i && ((head_i.cmd != CMD_READ) || out_free);
  assign load_out = pop_o && (head_i.cmd == CMD_READ);

  assign dsq_sum = {1'b0, dsq_q[idx]} + (DSQ_W + 1)'(head_i.r2);
  assign dsq_new = dsq_sum[DSQ_W] ? {DSQ_W{1'b1}} : dsq_sum[DSQ_W-1:0];
  assign dx_new  = sat_add(dx_q[idx], head_i.dx);
  assign dy_new  = sat_add(dy_q[idx], head_i.dy);
  assign dz_new  = sat_add(dz_q[idx], head_i.dz);
  assign cnt_new = (&cnt_q[idx]) ? cnt_q[idx] : cnt_q[idx] + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SHELLS; k++) begin
        dsq_q[k] <= '0;
        dx_q[k]  <= '0;
        dy_q[k]  <= '0;
        dz_q[k]  <= '0;
        cnt_q[k] <= '0;
      end
    end else if (pop_o) begin
      case (head_i.cmd)
        CMD_ACCUM: begin
          dsq_q[idx] <= dsq_new;
          dx_q[idx]  <= dx_new;
          dy_q[idx]  <= dy_new;
          dz_q[idx]  <= dz_new;
          cnt_q[idx] <= cnt_new;
        end
        CMD_CLEAR: begin
          for (int k = 0; k < NUM_SHELLS; k++) begin
            dsq_q[k] <= '0;
            dx_q[k]  <= '0;
            dy_q[k]  <= '0;
            dz_q[k]  <= '0;
            cnt_q[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (head_i.shell_ok) begin
        out_data_q <= {cnt_q[idx], dz_q[idx], dy_q[idx], dx_q[idx], dsq_q[idx]};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sim/neighbor_distance_shell_accumulator_tb.sv =====
`timescale 1ns / 1ps

module neighbor_distance_shell_accumulator_tb;
  import ndsa_pkg::*;

  localparam int unsigned NUM_SHELLS       = NUM_SHELLS_DEF;
  localparam int unsigned LATENCY_SLACK    = 8;
  localparam int unsigned DRAIN_LIMIT      = 20000;
  localparam int unsigned SINK_HOLD_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS      = 255;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam longint SUM48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM48_MIN = -SUM48_MAX - 1;

  // One input transfer: command in tuser, positions and shell in tdata
  typedef struct {
    cmd_e                     cmd;
    logic signed [POS_W-1:0]  own[3];
    logic signed [POS_W-1:0]  nbr[3];
    logic [SEL_W-1:0]         shell_sel;
  } pair_cmd_t;

  // m_axis_tdata from the lowest bit up: sum_dist_sq, sum_dx, sum_dy, sum_dz, pair_count
  typedef struct packed {
    logic [CNT_W-1:0]  pair_count;
    logic [DSUM_W-1:0] sum_dz;
    logic [DSUM_W-1:0] sum_dy;
    logic [DSUM_W-1:0] sum_dx;
    logic [DSQ_W-1:0]  sum_dist_sq;
  } shell_sums_t;

  class shell_histogram_model;
    logic [BOUND_W-1:0] bound_sq[3];
    logic [DSQ_W-1:0]   dsq_sum[NUM_SHELLS];
    longint             diff_sum[NUM_SHELLS][3];
    logic [CNT_W-1:0]   pairs[NUM_SHELLS];
    shell_sums_t        pending_readouts[$];
    int unsigned        errors;

    function new();
      bound_sq[0] = BOUND_SQ_1_RST;
      bound_sq[1] = BOUND_SQ_MAX;
      bound_sq[2] = BOUND_SQ_MAX;
      errors = 0;
      clear_shells();
    endfunction

    function void clear_shells();
      for (int k = 0; k < NUM_SHELLS; k++) begin
        dsq_sum[k] = '0;
        pairs[k] = '0;
        for (int j = 0; j < 3; j++) diff_sum[k][j] = 0;
      end
    endfunction

    function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [BOUND_W-1:0] val);
      if (idx <= CFG_BOUND_SQ_3) bound_sq[idx] = val;
    endfunction

    function void note_transfer(pair_cmd_t it);
      longint      d[3];
      longint      s;
      logic [63:0] r2;
      int          k;
      shell_sums_t res;
      case (it.cmd)
        CMD_ACCUM: begin
          for (int j = 0; j < 3; j++) d[j] = longint'(it.own[j]) - longint'(it.nbr[j]);
          r2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
          // first shell whose bound exceeds r2; the last shell is open
          k = 0;
          while (k < NUM_SHELLS - 1 && !(bound_sq[k] > r2)) k++;
          if (dsq_sum[k] > ~r2) dsq_sum[k] = '1;
          else dsq_sum[k] = dsq_sum[k] + r2;
          for (int j = 0; j < 3; j++) begin
            s = diff_sum[k][j] + d[j];
            if (s > SUM48_MAX) s = SUM48_MAX;
            if (s < SUM48_MIN) s = SUM48_MIN;
            diff_sum[k][j] = s;
          end
          if (pairs[k] != '1) pairs[k] = pairs[k] + 1'b1;
        end
        CMD_READ: begin
          res = '0;
          if (it.shell_sel < NUM_SHELLS) begin
            res.sum_dist_sq = dsq_sum[it.shell_sel];
            res.sum_dx = diff_sum[it.shell_sel][0][DSUM_W-1:0];
            res.sum_dy = diff_sum[it.shell_sel][1][DSUM_W-1:0];
            res.sum_dz = diff_sum[it.shell_sel][2][DSUM_W-1:0];
            res.pair_count = pairs[it.shell_sel];
          end
          pending_readouts.push_back(res);
        end
        CMD_CLEAR: clear_shells();
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_readout(logic [OUT_DATA_W-1:0] word);
      shell_sums_t got;
      shell_sums_t want;
      got = shell_sums_t'(word);
      if (pending_readouts.size() == 0) begin
        $error("read result 0x%0h arrived with none outstanding", word);
        errors++;
      end else begin
        want = pending_readouts.pop_front();
        check_field("sum_dist_sq", want.sum_dist_sq, got.sum_dist_sq);
        check_field("sum_dx", want.sum_dx, got.sum_dx);
        check_field("sum_dy", want.sum_dy, got.sum_dy);
        check_field("sum_dz", want.sum_dz, got.sum_dz);
        check_field("pair_count", want.pair_count, got.pair_count);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [BOUND_W-1:0]    cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  shell_histogram_model shells = new();
  bit hold_sink   = 1'b0;
  bit src_no_gaps = 1'b0;

  neighbor_distance_shell_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) shells.check_readout(m_axis_tdata);
  end

  // Sink: random stalls, calm stretches, and one long hold on request
  initial begin
    int unsigned stall_left = 0;
    int unsigned cyc = 0;
    int unsigned r;
    bit steady = 1'b0;
    logic rdy;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready = 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(negedge clk_i);
        hold_sink = 1'b0;
      end else begin
        cyc++;
        if (cyc % 256 == 0) steady = ($urandom_range(0, 99) < 30);
        if (stall_left != 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if (!steady && $urandom_range(0, 99) < 15) begin
            r = $urandom_range(0, 99);
            stall_left = (r < 80) ? $urandom_range(1, 3) :
                         (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 50);
            stall_left--;
            rdy = 1'b0;
          end
        end
        m_axis_tready = rdy;
      end
    end
  end

  function automatic pair_cmd_t make_pair(cmd_e cmd, logic signed [POS_W-1:0] o0,
                                          logic signed [POS_W-1:0] o1,
                                          logic signed [POS_W-1:0] o2,
                                          logic signed [POS_W-1:0] n0,
                                          logic signed [POS_W-1:0] n1,
                                          logic signed [POS_W-1:0] n2,
                                          logic [SEL_W-1:0] sel);
    pair_cmd_t it;
    it.cmd = cmd;
    it.own[0] = o0;
    it.own[1] = o1;
    it.own[2] = o2;
    it.nbr[0] = n0;
    it.nbr[1] = n1;
    it.nbr[2] = n2;
    it.shell_sel = sel;
    return it;
  endfunction

  function automatic logic signed [POS_W-1:0] extreme_pos();
    case ($urandom_range(0, 3))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'sh000000;
      default: return 24'shFFFFFF;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] random_pos();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 9) == 0) return extreme_pos();
    return w[POS_W-1:0];
  endfunction

  function automatic pair_cmd_t random_pair(int unsigned read_pct);
    pair_cmd_t it;
    int unsigned r;
    logic [31:0] w;
    logic signed [POS_W-1:0] delta;
    r = $urandom_range(0, 99);
    if (r < 5) it.cmd = CMD_NOP;
    else if (r < 5 + read_pct) it.cmd = CMD_READ;
    else if (r < 8 + read_pct) it.cmd = CMD_CLEAR;
    else it.cmd = CMD_ACCUM;
    it.shell_sel = SEL_W'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) begin
      it.own[j] = random_pos();
      // scale the offset so pairs land across all shell radii
      w = $urandom();
      delta = $signed(w[POS_W-1:0]) >>> $urandom_range(0, POS_W - 1);
      if (r < 5) it.nbr[j] = it.own[j] - delta;
      else if (r < 8) it.nbr[j] = random_pos();
      else if (r < 9) it.nbr[j] = it.own[j];
      else it.nbr[j] = extreme_pos();
    end
    return it;
  endfunction

  task automatic send_pair(pair_cmd_t it);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.cmd;
    s_axis_tdata  = {6'b0, it.shell_sel, it.nbr[2], it.nbr[1], it.nbr[0],
                     it.own[2], it.own[1], it.own[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    shells.note_transfer(it);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (src_no_gaps || r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic wait_readouts_drained();
    int unsigned waited = 0;
    while (shells.pending_readouts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
  endtask

  // Bounds change only with the pipeline empty: drain reads, then let accumulates retire
  task automatic quiesce();
    s_axis_tvalid = 1'b0;
    wait_readouts_drained();
    repeat (LATENCY_SLACK) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOUND_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    shells.set_bound(idx, val);
    @(negedge clk_i);
  endtask

  task automatic load_bounds(logic [BOUND_W-1:0] b1, logic [BOUND_W-1:0] b2,
                             logic [BOUND_W-1:0] b3);
    quiesce();
    write_reg(CFG_BOUND_SQ_1, b1);
    write_reg(CFG_BOUND_SQ_2, b2);
    write_reg(CFG_BOUND_SQ_3, b3);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random_phase(int unsigned n_items, int unsigned read_pct,
                                  bit no_gaps, bit pause_midway);
    int unsigned done = 0;
    pair_cmd_t it;
    src_no_gaps = no_gaps;
    while (done < n_items) begin
      it = random_pair(read_pct);
      if (it.cmd != CMD_NOP) done++;
      send_pair(it);
      if (pause_midway && it.cmd != CMD_NOP && done == n_items / 2) begin
        s_axis_tvalid = 1'b0;
        wait_readouts_drained();
      end else begin
        sender_gap();
      end
    end
    s_axis_tvalid = 1'b0;
    src_no_gaps = 1'b0;
  endtask

  function automatic logic [BOUND_W-1:0] random_bound();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[BOUND_W-1:0];
  endfunction

  initial begin
    pair_cmd_t directed[$];
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_NOP;
    rst_ni        = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset bounds: shell 0 below 1.5, everything else in shell 1
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd0));
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd3));
    directed.push_back(make_pair(CMD_ACCUM, 0, 0, 0, 0, 0, 0, 2'd0));
    directed.push_back(make_pair(CMD_ACCUM, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                                 24'sh800000, 24'sh800000, 24'sh800000, 2'd3));
    directed.push_back(make_pair(CMD_ACCUM, 24'sh800000, 24'sh800000, 24'sh800000,
                                 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 2'd0));
    // r2 equal to the shell 0 bound goes outward; one step short stays inside
    directed.push_back(make_pair(CMD_ACCUM, 6144, 0, 0, 0, 0, 0, 2'd0));
    directed.push_back(make_pair(CMD_ACCUM, 0, 0, 0, 6143, 0, 0, 2'd0));
    directed.push_back(make_pair(CMD_ACCUM, 24'sh7FFFFF, 24'sh800000, 0,
                                 -1, 24'sh7FFFFF, 0, 2'd1));
    directed.push_back(make_pair(CMD_NOP, -1, -1, -1, 24'sh7FFFFF, 5, 24'sh800000, 2'd3));
    directed.push_back(make_pair(CMD_READ, -1, -1, -1, -1, -1, -1, 2'd0));
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd1));
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd2));
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd3));
    directed.push_back(make_pair(CMD_CLEAR, 7, 7, 7, 7, 7, 7, 2'd1));
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd1));
    directed.push_back(make_pair(CMD_ACCUM, 1, 2, 3, -1, -2, -3, 2'd0));
    directed.push_back(make_pair(CMD_READ, 0, 0, 0, 0, 0, 0, 2'd0));
    foreach (directed[i]) begin
      send_pair(directed[i]);
      sender_gap();
    end
    s_axis_tvalid = 1'b0;

    run_random_phase(PHASE_ITEMS, 20, 1'b0, 1'b0);

    // All bounds zero: every pair falls through to the open last shell.
    // Hold the sink long enough for the input side to back up.
    load_bounds('0, '0, '0);
    hold_sink = 1'b1;
    run_random_phase(PHASE_ITEMS, 40, 1'b1, 1'b0);

    // All bounds at maximum: every pair lands in shell 0; the spare index is ignored
    load_bounds(BOUND_SQ_MAX, BOUND_SQ_MAX, BOUND_SQ_MAX);
    write_reg(CFG_SPARE_IDX, random_bound());
    cfg_we_i = 1'b0;
    run_random_phase(PHASE_ITEMS, 20, 1'b0, 1'b1);

    load_bounds(50'd1 << 30, 50'd1 << 38, 50'd1 << 46);
    run_random_phase(PHASE_ITEMS, 20, 1'b1, 1'b0);

    load_bounds(random_bound() >> 8, random_bound() >> 4, random_bound());
    run_random_phase(PHASE_ITEMS, 20, 1'b0, 1'b0);

    // Bounds out of order: a later shell may be unreachable
    load_bounds(50'd1 << 20, 50'd1 << 44, 50'd1 << 28);
    run_random_phase(PHASE_ITEMS, 20, 1'b0, 1'b0);

    quiesce();
    if (shells.pending_readouts.size() != 0) begin
      $error("%0d read results never arrived", shells.pending_readouts.size());
      shells.errors++;
    end
    if (shells.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ndsa_pkg.sv
src/ndsa_front.sv
src/ndsa_queue.sv
src/ndsa_back.sv
src/neighbor_distance_shell_accumulator.sv
sim/neighbor_distance_shell_accumulator_tb.sv
